### sv/tmsw_pkg.sv
`timescale 1ns / 1ps
// Package for the text mode screen writer: command codes, sequencer states,
// field widths and default screen size. No dependencies.
package tmsw_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 2 * CHAR_W;

  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

  typedef enum logic [1:0] {
    CMD_PRINT      = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_WRITE_CELL = 2'd2,
    CMD_READ_CELL  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL
  } state_e;

endpackage

### sv/text_mode_screen_writer.sv
`timescale 1ns / 1ps
// Text mode screen writer: cell store, cursor and the sequencer that prints,
// writes, reads and scrolls through the cell store. Depends on tmsw_pkg.

// Print, set cursor and write cell: the word is accepted, any cell is written
// at that edge and the result strobe (done_o) follows in the next cycle, with
// busy_o low so a new word may be started right then. Read cell passes through
// ST_READ before done_o because the cell store has a registered read port. A
// print that moves past the last row scrolls the screen: the cell store's read
// port fetches one row down while its write port stores one row up, one cell
// per cycle, and then fills the bottom row, with busy_o high. After reset the
// store is cleared one cell per cycle, with busy_o high. Results cannot be held
// off: done_o is a strobe, and the results stay on the ports until the next
// word is accepted.
module text_mode_screen_writer #(
  parameter int COLUMNS = tmsw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = tmsw_pkg::ROWS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy_o,
  input  logic [1:0]                    cmd_i,
  input  logic [tmsw_pkg::COL_W-1:0]    col_i,
  input  logic [tmsw_pkg::ROW_W-1:0]    row_i,
  input  logic [tmsw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tmsw_pkg::CHAR_W-1:0]   attribute_i,
  input  logic                          last_of_text_i,
  output logic                          done_o,
  output logic [tmsw_pkg::COL_W-1:0]    cursor_col_o,
  output logic [tmsw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tmsw_pkg::CHAR_W-1:0]   read_char_o,
  output logic [tmsw_pkg::CHAR_W-1:0]   read_attribute_o,
  output logic                          scrolled_o,
  output logic                          rejected_o,
  output logic                          end_of_text_o
);

  localparam int N  = COLUMNS * ROWS;
  localparam int AW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  localparam logic [AW-1:0] COLS_A       = AW'(COLUMNS);
  localparam logic [CW-1:0] CNT_COLS     = CW'(COLUMNS);
  localparam logic [CW-1:0] CNT_LAST     = CW'(N);
  localparam logic [CW-1:0] CNT_CLR_LAST = CW'(N - 1);
  localparam logic [CW-1:0] CNT_FILL     = CW'(N - COLUMNS);

  localparam logic [tmsw_pkg::COL_W:0]   COL_LIM  = (tmsw_pkg::COL_W + 1)'(COLUMNS);
  localparam logic [tmsw_pkg::ROW_W:0]   ROW_LIM  = (tmsw_pkg::ROW_W + 1)'(ROWS);
  localparam logic [tmsw_pkg::COL_W-1:0] COL_LAST = tmsw_pkg::COL_W'(COLUMNS - 1);
  localparam logic [tmsw_pkg::ROW_W-1:0] ROW_LAST = tmsw_pkg::ROW_W'(ROWS - 1);

  // cell store: character in the low byte, attribute in the high byte
  logic [tmsw_pkg::CELL_W-1:0] mem [N];
  logic [tmsw_pkg::CELL_W-1:0] mem_rd_q;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  logic [AW-1:0]               mem_ra;
  logic [tmsw_pkg::CELL_W-1:0] mem_wd;

  tmsw_pkg::state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic [tmsw_pkg::COL_W-1:0]  cur_col_q, cur_col_d;
  logic [tmsw_pkg::ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [tmsw_pkg::CHAR_W-1:0] fill_attr_q, fill_attr_d;

  // pending scroll write, registered behind its read
  logic          wr_pend_q, wr_pend_d;
  logic [AW-1:0] wr_addr_q, wr_addr_d;
  logic          wr_fill_q, wr_fill_d;

  logic                        done_q, done_d;
  logic [tmsw_pkg::CHAR_W-1:0] rd_char_q, rd_char_d;
  logic [tmsw_pkg::CHAR_W-1:0] rd_attr_q, rd_attr_d;
  logic                        scrolled_q, scrolled_d;
  logic                        rejected_q, rejected_d;
  logic                        eot_q, eot_d;

  logic          accept;
  logic          on_screen;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] cur_addr;
  logic [CW-1:0] scroll_src;
  logic          at_last_row;
  tmsw_pkg::cmd_e cmd;

  assign cmd         = tmsw_pkg::cmd_e'(cmd_i);
  assign busy_o      = (state_q != tmsw_pkg::ST_IDLE);
  assign accept      = start && !busy_o;
  assign on_screen   = ({1'b0, col_i} < COL_LIM) && ({1'b0, row_i} < ROW_LIM);
  assign in_addr     = AW'(AW'(row_i) * COLS_A + AW'(col_i));
  assign cur_addr    = AW'(AW'(cur_row_q) * COLS_A + AW'(cur_col_q));
  assign scroll_src  = cnt_q + CNT_COLS;
  assign at_last_row = (cur_row_q == ROW_LAST);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_rd_q <= mem[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tmsw_pkg::ST_CLEAR;
      cnt_q     <= '0;
      cur_col_q <= '0;
      cur_row_q <= '0;
      wr_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      wr_pend_q <= wr_pend_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_attr_q <= fill_attr_d;
    wr_addr_q   <= wr_addr_d;
    wr_fill_q   <= wr_fill_d;
    rd_char_q   <= rd_char_d;
    rd_attr_q   <= rd_attr_d;
    scrolled_q  <= scrolled_d;
    rejected_q  <= rejected_d;
    eot_q       <= eot_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cur_col_d   = cur_col_q;
    cur_row_d   = cur_row_q;
    fill_attr_d = fill_attr_q;
    wr_pend_d   = 1'b0;
    wr_addr_d   = wr_addr_q;
    wr_fill_d   = wr_fill_q;
    done_d      = 1'b0;
    rd_char_d   = rd_char_q;
    rd_attr_d   = rd_attr_q;
    scrolled_d  = scrolled_q;
    rejected_d  = rejected_q;
    eot_d       = eot_q;
    mem_we      = 1'b0;
    mem_wa      = in_addr;
    mem_wd      = {attribute_i, char_code_i};
    mem_ra      = in_addr;

    unique case (state_q)
      tmsw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = cnt_q[AW-1:0];
        mem_wd = '0;
        if (cnt_q == CNT_CLR_LAST) begin
          cnt_d   = '0;
          state_d = tmsw_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      tmsw_pkg::ST_IDLE: begin
        if (accept) begin
          rd_char_d   = '0;
          rd_attr_d   = '0;
          scrolled_d  = 1'b0;
          rejected_d  = 1'b0;
          eot_d       = last_of_text_i;
          fill_attr_d = attribute_i;
          done_d      = 1'b1;
          if (cmd == tmsw_pkg::CMD_PRINT) begin
            mem_wa = cur_addr;
            if (char_code_i == tmsw_pkg::NEWLINE_CODE) begin
              cur_col_d = '0;
              if (at_last_row) begin
                done_d     = 1'b0;
                scrolled_d = 1'b1;
                state_d    = tmsw_pkg::ST_SCROLL;
              end else begin
                cur_row_d = cur_row_q + 1'b1;
              end
            end else begin
              mem_we = 1'b1;
              if (cur_col_q == COL_LAST) begin
                cur_col_d = '0;
                if (at_last_row) begin
                  done_d     = 1'b0;
                  scrolled_d = 1'b1;
                  state_d    = tmsw_pkg::ST_SCROLL;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                end
              end else begin
                cur_col_d = cur_col_q + 1'b1;
              end
            end
          end else if (!on_screen) begin
            rejected_d = 1'b1;
          end else begin
            unique case (cmd)
              tmsw_pkg::CMD_SET_CURSOR: begin
                cur_col_d = col_i;
                cur_row_d = row_i;
              end
              tmsw_pkg::CMD_WRITE_CELL: begin
                mem_we = 1'b1;
              end
              tmsw_pkg::CMD_READ_CELL: begin
                done_d  = 1'b0;
                state_d = tmsw_pkg::ST_READ;
              end
              default: begin
                // print is handled above
                done_d = 1'b1;
              end
            endcase
          end
        end
      end

      tmsw_pkg::ST_READ: begin
        rd_char_d = mem_rd_q[tmsw_pkg::CHAR_W-1:0];
        rd_attr_d = mem_rd_q[tmsw_pkg::CELL_W-1:tmsw_pkg::CHAR_W];
        done_d    = 1'b1;
        state_d   = tmsw_pkg::ST_IDLE;
      end

      tmsw_pkg::ST_SCROLL: begin
        // read one row down now, write it one row up next cycle
        mem_ra = scroll_src[AW-1:0];
        mem_we = wr_pend_q;
        mem_wa = wr_addr_q;
        mem_wd = wr_fill_q ? {fill_attr_q, tmsw_pkg::SPACE_CODE} : mem_rd_q;
        if (cnt_q == CNT_LAST) begin
          cnt_d   = '0;
          done_d  = 1'b1;
          state_d = tmsw_pkg::ST_IDLE;
        end else begin
          wr_pend_d = 1'b1;
          wr_addr_d = cnt_q[AW-1:0];
          wr_fill_d = (cnt_q >= CNT_FILL);
          cnt_d     = cnt_q + 1'b1;
        end
      end

      default: begin
        state_d = tmsw_pkg::ST_IDLE;
      end
    endcase
  end

  assign done_o           = done_q;
  assign cursor_col_o     = cur_col_q;
  assign cursor_row_o     = cur_row_q;
  assign read_char_o      = rd_char_q;
  assign read_attribute_o = rd_attr_q;
  assign scrolled_o       = scrolled_q;
  assign rejected_o       = rejected_q;
  assign end_of_text_o    = eot_q;

`ifndef SYNTHESIS
  a_cursor_on_screen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < COL_LIM) && ({1'b0, cur_row_q} < ROW_LIM))
    else $error("cursor left the screen");

  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && scrolled_o) |-> (cursor_row_o == ROW_LAST) && (cursor_col_o == '0))
    else $error("scroll result with cursor off the bottom row start");

  a_scroll_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tmsw_pkg::ST_SCROLL && cnt_q == CNT_LAST) |=> done_o && scrolled_o)
    else $error("scroll finished without a result");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rejected_o) |-> !scrolled_o && read_char_o == '0 && read_attribute_o == '0)
    else $error("rejected word carries data");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for text_mode_screen_writer: a queue-fed driver, a strobe monitor and a
// screen predictor that tracks cells, cursor and scrolling. Depends on tmsw_pkg and the RTL.
module testbench;

  localparam int COLUMNS    = tmsw_pkg::COLUMNS_DEFAULT;
  localparam int ROWS       = tmsw_pkg::ROWS_DEFAULT;
  localparam int WORD_COUNT = 1250;
  localparam int TAIL_WAIT  = 20;

  typedef struct {
    tmsw_pkg::cmd_e              cmd;
    logic [tmsw_pkg::COL_W-1:0]  col;
    logic [tmsw_pkg::ROW_W-1:0]  row;
    logic [tmsw_pkg::CHAR_W-1:0] ch;
    logic [tmsw_pkg::CHAR_W-1:0] attr;
    logic                        last;
    bit                          drain;
  } screen_word_t;

  typedef struct packed {
    logic [tmsw_pkg::COL_W-1:0]  cursor_col;
    logic [tmsw_pkg::ROW_W-1:0]  cursor_row;
    logic [tmsw_pkg::CHAR_W-1:0] read_char;
    logic [tmsw_pkg::CHAR_W-1:0] read_attr;
    logic                        scrolled;
    logic                        rejected;
    logic                        end_of_text;
  } screen_report_t;

  logic                        clk_i          = 1'b0;
  logic                        rst_ni         = 1'b0;
  logic                        start          = 1'b0;
  logic [1:0]                  cmd_i          = '0;
  logic [tmsw_pkg::COL_W-1:0]  col_i          = '0;
  logic [tmsw_pkg::ROW_W-1:0]  row_i          = '0;
  logic [tmsw_pkg::CHAR_W-1:0] char_code_i    = '0;
  logic [tmsw_pkg::CHAR_W-1:0] attribute_i    = '0;
  logic                        last_of_text_i = 1'b0;
  logic                        busy_o, done_o;
  logic [tmsw_pkg::COL_W-1:0]  cursor_col_o;
  logic [tmsw_pkg::ROW_W-1:0]  cursor_row_o;
  logic [tmsw_pkg::CHAR_W-1:0] read_char_o, read_attribute_o;
  logic                        scrolled_o, rejected_o, end_of_text_o;

  text_mode_screen_writer u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy_o           (busy_o),
    .cmd_i            (cmd_i),
    .col_i            (col_i),
    .row_i            (row_i),
    .char_code_i      (char_code_i),
    .attribute_i      (attribute_i),
    .last_of_text_i   (last_of_text_i),
    .done_o           (done_o),
    .cursor_col_o     (cursor_col_o),
    .cursor_row_o     (cursor_row_o),
    .read_char_o      (read_char_o),
    .read_attribute_o (read_attribute_o),
    .scrolled_o       (scrolled_o),
    .rejected_o       (rejected_o),
    .end_of_text_o    (end_of_text_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted screen contents and cursor.
  logic [tmsw_pkg::CELL_W-1:0] screen_mem [ROWS][COLUMNS];
  int                          cur_col, cur_row;

  screen_word_t   word_q[$];
  screen_report_t due_reports[$];
  screen_word_t   word_on_bus;
  int unsigned    accepted_cnt = 0;
  int unsigned    received_cnt = 0;
  int unsigned    words_sent   = 0;
  int unsigned    mismatches   = 0;

  function automatic screen_report_t predict_screen_word(screen_word_t w);
    screen_report_t r;
    r = '0;
    r.end_of_text = w.last;
    if (w.cmd == tmsw_pkg::CMD_PRINT) begin
      if (w.ch == tmsw_pkg::NEWLINE_CODE) begin
        cur_col = 0;
        cur_row++;
      end else begin
        screen_mem[cur_row][cur_col] = {w.attr, w.ch};
        if (cur_col + 1 < COLUMNS) begin
          cur_col++;
        end else begin
          cur_col = 0;
          cur_row++;
        end
      end
      // Shift every line up and blank the bottom one in the word's attribute.
      if (cur_row >= ROWS) begin
        for (int ln = 1; ln < ROWS; ln++) screen_mem[ln-1] = screen_mem[ln];
        for (int c = 0; c < COLUMNS; c++)
          screen_mem[ROWS-1][c] = {w.attr, tmsw_pkg::SPACE_CODE};
        cur_row    = ROWS - 1;
        r.scrolled = 1'b1;
      end
    end else if (w.col >= COLUMNS || w.row >= ROWS) begin
      r.rejected = 1'b1;
    end else if (w.cmd == tmsw_pkg::CMD_SET_CURSOR) begin
      cur_col = w.col;
      cur_row = w.row;
    end else if (w.cmd == tmsw_pkg::CMD_WRITE_CELL) begin
      screen_mem[w.row][w.col] = {w.attr, w.ch};
    end else begin
      {r.read_attr, r.read_char} = screen_mem[w.row][w.col];
    end
    r.cursor_col = tmsw_pkg::COL_W'(cur_col);
    r.cursor_row = tmsw_pkg::ROW_W'(cur_row);
    return r;
  endfunction

  task automatic push_word(tmsw_pkg::cmd_e cmd, int col, int row, int ch, int attr, bit last,
                           bit drain = 1'b0);
    screen_word_t w;
    w.cmd   = cmd;
    w.col   = tmsw_pkg::COL_W'(col);
    w.row   = tmsw_pkg::ROW_W'(row);
    w.ch    = tmsw_pkg::CHAR_W'(ch);
    w.attr  = tmsw_pkg::CHAR_W'(attr);
    w.last  = last;
    w.drain = drain;
    word_q.push_back(w);
  endtask

  // Random position: mostly on screen, now and then anywhere the fields reach.
  task automatic pick_position(output int col, output int row);
    if ($urandom_range(7) == 0) begin
      col = $urandom_range(127);
      row = $urandom_range(31);
    end else begin
      col = $urandom_range(COLUMNS - 1);
      row = $urandom_range(ROWS - 1);
    end
  endtask

  task automatic queue_random_words(int n);
    int             kind, len, col, row, attr, ch;
    bit             drain;
    tmsw_pkg::cmd_e cmd;
    while (word_q.size() < n) begin
      kind  = $urandom_range(99);
      drain = ($urandom_range(99) < 2);
      if (kind < 55) begin
        len  = $urandom_range(1, 16);
        attr = $urandom_range(255);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(15) == 0) ? tmsw_pkg::NEWLINE_CODE : $urandom_range(255);
          push_word(tmsw_pkg::CMD_PRINT, $urandom_range(127), $urandom_range(31), ch, attr,
                    i == len - 1, drain && i == 0);
        end
      end else if (kind < 91) begin
        cmd = (kind < 67) ? tmsw_pkg::CMD_SET_CURSOR :
              (kind < 79) ? tmsw_pkg::CMD_WRITE_CELL : tmsw_pkg::CMD_READ_CELL;
        pick_position(col, row);
        push_word(cmd, col, row, $urandom_range(255), $urandom_range(255),
                  $urandom_range(1), drain);
      end else begin
        // Noise: anything the fields allow.
        push_word(tmsw_pkg::cmd_e'(2'($urandom_range(3))), $urandom_range(127),
                  $urandom_range(31), $urandom_range(255), $urandom_range(255),
                  $urandom_range(1), drain);
      end
    end
  endtask

  // Driver: hold a word until accepted, then predict it and start the next one.
  always @(posedge clk_i) begin
    bit          fire, go;
    int unsigned open_words;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      fire = start && !busy_o;
      if (fire) begin
        due_reports.push_back(predict_screen_word(word_on_bus));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!start || fire) begin
        open_words = accepted_cnt + fire - received_cnt - done_o;
        go = word_q.size() != 0;
        if ($urandom_range(99) < 10 && !(words_sent >= 500 && words_sent < 750)) go = 1'b0;
        if (go && word_q[0].drain && open_words != 0) go = 1'b0;
        if (go) begin
          word_on_bus = word_q.pop_front();
          words_sent++;
          start          <= 1'b1;
          cmd_i          <= word_on_bus.cmd;
          col_i          <= word_on_bus.col;
          row_i          <= word_on_bus.row;
          char_code_i    <= word_on_bus.ch;
          attribute_i    <= word_on_bus.attr;
          last_of_text_i <= word_on_bus.last;
        end else begin
          start          <= 1'b0;
          cmd_i          <= 2'($urandom_range(3));
          col_i          <= tmsw_pkg::COL_W'($urandom_range(127));
          row_i          <= tmsw_pkg::ROW_W'($urandom_range(31));
          char_code_i    <= tmsw_pkg::CHAR_W'($urandom_range(255));
          attribute_i    <= tmsw_pkg::CHAR_W'($urandom_range(255));
          last_of_text_i <= 1'($urandom_range(1));
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    screen_report_t got, want;
    if (rst_ni && done_o) begin
      got = {cursor_col_o, cursor_row_o, read_char_o, read_attribute_o,
             scrolled_o, rejected_o, end_of_text_o};
      received_cnt <= received_cnt + 1;
      if (due_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result at %0t ns", $realtime);
      end else begin
        want = due_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t ns: expected col=%0d row=%0d ch=%02h attr=%02h",
                     $realtime, want.cursor_col, want.cursor_row, want.read_char,
                     want.read_attr, " scr=%0b rej=%0b eot=%0b", want.scrolled,
                     want.rejected, want.end_of_text);
            $display("  got col=%0d row=%0d ch=%02h attr=%02h scr=%0b rej=%0b eot=%0b",
                     got.cursor_col, got.cursor_row, got.read_char, got.read_attr,
                     got.scrolled, got.rejected, got.end_of_text);
          end
        end
      end
    end
  end

  initial begin
    for (int ln = 0; ln < ROWS; ln++)
      for (int c = 0; c < COLUMNS; c++) screen_mem[ln][c] = '0;
    cur_col = 0;
    cur_row = 0;

    // Directed: wrap, scroll on wrap and on newline, rejects, field extremes.
    push_word(tmsw_pkg::CMD_PRINT, 0, 0, 8'h41, 8'h07, 1'b0);
    push_word(tmsw_pkg::CMD_PRINT, 0, 0, 8'hFF, 8'hFF, 1'b1);
    push_word(tmsw_pkg::CMD_PRINT, 0, 0, tmsw_pkg::NEWLINE_CODE, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_PRINT, 0, 0, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_SET_CURSOR, COLUMNS - 1, 0, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_PRINT, 0, 0, 8'h5A, 8'h1E, 1'b1);
    push_word(tmsw_pkg::CMD_SET_CURSOR, COLUMNS - 1, ROWS - 1, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_PRINT, 127, 31, 8'h7E, 8'h5A, 1'b0);
    push_word(tmsw_pkg::CMD_PRINT, 0, 0, tmsw_pkg::NEWLINE_CODE, 8'hC3, 1'b1);
    push_word(tmsw_pkg::CMD_READ_CELL, 0, ROWS - 1, 8'h00, 8'h00, 1'b0, 1'b1);
    push_word(tmsw_pkg::CMD_READ_CELL, COLUMNS - 1, ROWS - 2, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_SET_CURSOR, COLUMNS, 0, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_SET_CURSOR, 0, ROWS, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_SET_CURSOR, 127, 31, 8'hFF, 8'hFF, 1'b1);
    push_word(tmsw_pkg::CMD_WRITE_CELL, 0, 0, tmsw_pkg::NEWLINE_CODE, 8'h80, 1'b0);
    push_word(tmsw_pkg::CMD_WRITE_CELL, COLUMNS - 1, ROWS - 1, 8'hFF, 8'hFF, 1'b1);
    push_word(tmsw_pkg::CMD_WRITE_CELL, COLUMNS, ROWS - 1, 8'h11, 8'h22, 1'b0);
    push_word(tmsw_pkg::CMD_WRITE_CELL, 0, 31, 8'h33, 8'h44, 1'b0);
    push_word(tmsw_pkg::CMD_READ_CELL, 0, 0, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_READ_CELL, COLUMNS - 1, ROWS - 1, 8'h00, 8'h00, 1'b1);
    push_word(tmsw_pkg::CMD_READ_CELL, 127, 31, 8'hFF, 8'hFF, 1'b0);
    push_word(tmsw_pkg::CMD_READ_CELL, 127, 0, 8'h00, 8'h00, 1'b0);
    push_word(tmsw_pkg::CMD_SET_CURSOR, 0, 0, 8'h00, 8'h00, 1'b1);
    push_word(tmsw_pkg::CMD_PRINT, 127, 31, tmsw_pkg::SPACE_CODE, 8'h00, 1'b1);
    queue_random_words(WORD_COUNT);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sample on the falling edge so the driver's updates have settled.
    do @(negedge clk_i);
    while (word_q.size() != 0 || start || accepted_cnt != received_cnt);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (due_reports.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Covers every word scrolling with the slowest sender, many times over.
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
